>>> rtl/core/pcs_pkg.sv
`default_nettype none

package pcs_pkg;

    typedef logic [7:0]          t_level;
    typedef logic signed [8:0]   t_offset;
    typedef logic signed [16:0]  t_gain;

    localparam t_level      LEVEL_MAX = 8'd255;
    localparam logic [15:0] GAIN_NUM  = 16'd65280;
    localparam logic [15:0] GAIN_SAT  = 16'hFFFF;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_APPLY   = 1'b1;

    typedef enum logic [1:0] {
        CM_GRAY  = 2'd0,
        CM_RGB   = 2'd1,
        CM_YCC   = 2'd2,
        CM_OTHER = 2'd3
    } t_color_mode;

    typedef enum logic [1:0] {
        CFG_AUTO   = 2'd0,
        CFG_COLOR  = 2'd1,
        CFG_OFFSET = 2'd2,
        CFG_GAIN   = 2'd3
    } t_cfg_idx;

endpackage

`default_nettype wire

>>> rtl/core/pixel_contrast_stretch.sv
`default_nettype none
// channel   dir  handshake                  payload
// s_axis    in   tvalid / tready            tdata {ch_c, ch_b, ch_a}, tuser {first, operation}
// m_axis    out  tvalid / tready            tdata {out_c, out_b, out_a}
// cfg       in   we, no wait                addr 0..3, wdata 17 bits
// a measure item is taken in idle; an apply item sends channel a alone (gray, luma-chroma, other)
// or all three channels (rgb), one at a time, through the shared multiplier, then loads the output
// when the gain is stale and the range is not flat, the serial divider runs first
// ready is high only in idle; a held result stalls the next apply at its output load
// reset is synchronous, active low, and returns all config registers to defaults

module pixel_contrast_stretch (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // ch_a, ch_b, ch_c
    input  wire logic [1:0]  i_s_axis_tuser,   // operation, first_of_frame
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // out_a, out_b, out_c
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [16:0] i_cfg_wdata
);
    import pcs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_CLAMP,
        S_DONE
    } t_state;

    t_state      r_state;
    logic        r_auto;
    t_color_mode r_color_mode;
    t_offset     r_man_offset;
    t_gain       r_man_gain;
    t_level      r_dark;
    t_level      r_bright;
    logic        r_stale;
    logic [15:0] r_auto_gain;
    t_level      r_ch_a, r_ch_b, r_ch_c;
    t_level      r_res_a, r_res_b, r_res_c;
    logic [1:0]  r_idx;
    logic        r_out_valid;
    logic [23:0] r_out_data;

    logic        w_accept;
    logic        w_op;
    logic        w_first;
    t_level      w_a, w_b, w_c;
    logic        w_meas_all;
    t_level      n_dark, n_bright;
    logic        w_div_start;
    logic        w_div_done;
    logic [15:0] w_quot;
    t_level      w_mul_ch;
    t_offset     w_offset;
    t_gain       w_gain;
    t_level      w_level;
    logic        w_last;
    logic        w_load;
    t_level      w_out_b, w_out_c;

    function automatic t_level f_min(input t_level x, input t_level y);
        f_min = (y < x) ? y : x;
    endfunction

    function automatic t_level f_max(input t_level x, input t_level y);
        f_max = (y > x) ? y : x;
    endfunction

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_op     = i_s_axis_tuser[0];
    assign w_first  = i_s_axis_tuser[1];
    assign w_a      = i_s_axis_tdata[7:0];
    assign w_b      = i_s_axis_tdata[15:8];
    assign w_c      = i_s_axis_tdata[23:16];

    always_comb begin
        w_meas_all = (r_color_mode == CM_RGB) || (r_color_mode == CM_OTHER);
        n_dark     = f_min(w_first ? LEVEL_MAX : r_dark, w_a);
        n_bright   = f_max(w_first ? 8'd0 : r_bright, w_a);
        if (w_meas_all) begin
            n_dark   = f_min(f_min(n_dark, w_b), w_c);
            n_bright = f_max(f_max(n_bright, w_b), w_c);
        end
    end

    assign w_div_start = w_accept && (w_op == OP_APPLY) && r_stale && (r_bright > r_dark);

    pcs_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (r_bright - r_dark),
        .o_done    (w_div_done),
        .o_quot    (w_quot)
    );

    always_comb begin
        case (r_idx)
            2'd0:    w_mul_ch = r_ch_a;
            2'd1:    w_mul_ch = r_ch_b;
            default: w_mul_ch = r_ch_c;
        endcase
        w_offset = r_auto ? t_offset'({1'b0, r_dark}) : r_man_offset;
        w_gain   = r_auto ? t_gain'({1'b0, r_auto_gain}) : r_man_gain;
    end

    pcs_mul u_mul (
        .i_clk    (i_clk),
        .i_ch     (w_mul_ch),
        .i_offset (w_offset),
        .i_gain   (w_gain),
        .o_level  (w_level)
    );

    always_comb begin
        w_last = (r_idx == 2'd2) || (r_color_mode != CM_RGB);
        w_load = (r_state == S_DONE) && (!r_out_valid || i_m_axis_tready);
        case (r_color_mode)
            CM_GRAY: begin
                w_out_b = r_res_a;
                w_out_c = r_res_a;
            end
            CM_RGB: begin
                w_out_b = r_res_b;
                w_out_c = r_res_c;
            end
            default: begin
                w_out_b = r_ch_b;
                w_out_c = r_ch_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_auto       <= 1'b1;
            r_color_mode <= CM_RGB;
            r_man_offset <= '0;
            r_man_gain   <= 17'sd256;
            r_dark       <= LEVEL_MAX;
            r_bright     <= '0;
            r_stale      <= 1'b1;
            r_auto_gain  <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_addr))
                    CFG_AUTO:   r_auto       <= i_cfg_wdata[0];
                    CFG_COLOR:  r_color_mode <= t_color_mode'(i_cfg_wdata[1:0]);
                    CFG_OFFSET: r_man_offset <= t_offset'(i_cfg_wdata[8:0]);
                    CFG_GAIN:   r_man_gain   <= t_gain'(i_cfg_wdata);
                    default:    ;
                endcase
            end

            if (o_m_axis_tvalid && i_m_axis_tready && !w_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (w_op == OP_MEASURE) begin
                            r_dark   <= n_dark;
                            r_bright <= n_bright;
                            r_stale  <= 1'b1;
                        end else begin
                            r_ch_a <= w_a;
                            r_ch_b <= w_b;
                            r_ch_c <= w_c;
                            r_idx  <= '0;
                            if (w_div_start) begin
                                r_state <= S_DIV;
                            end else begin
                                if (r_stale) begin
                                    r_auto_gain <= GAIN_SAT;
                                    r_stale     <= 1'b0;
                                end
                                r_state <= S_MUL;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_auto_gain <= w_quot;
                        r_stale     <= 1'b0;
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_CLAMP;
                end
                S_CLAMP: begin
                    case (r_idx)
                        2'd0:    r_res_a <= w_level;
                        2'd1:    r_res_b <= w_level;
                        default: r_res_c <= w_level;
                    endcase
                    if (w_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_out_data  <= {w_out_c, w_out_b, r_res_a};
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_apply_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_APPLY)) |=> !o_s_axis_tready)
        else $error("apply item did not occupy the block");

    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_MEASURE)) |=> (r_dark <= r_bright))
        else $error("measured range inverted");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside gain update");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MUL) && (r_color_mode != CM_RGB)) |-> (r_idx == 2'd0))
        else $error("extra channel issued outside rgb");

endmodule

`default_nettype wire

>>> rtl/core/pcs_div.sv
`default_nettype none

module pcs_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire pcs_pkg::t_level i_divisor,
    output logic               o_done,
    output logic [15:0]        o_quot
);
    import pcs_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [7:0]  r_rem;
    logic [15:0] r_dvd;
    logic [15:0] r_quot;
    t_level      r_dsr;

    logic [8:0]  w_rem_s;
    logic [8:0]  w_diff;
    logic        w_ge;

    // one restoring step per cycle
    always_comb begin
        w_rem_s = {r_rem, r_dvd[15]};
        w_diff  = w_rem_s - {1'b0, r_dsr};
        w_ge    = (w_rem_s >= {1'b0, r_dsr});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 4'd15;
                r_rem  <= '0;
                r_dvd  <= GAIN_NUM;
                r_quot <= '0;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[7:0] : w_rem_s[7:0];
                r_quot <= {r_quot[14:0], w_ge};
                r_dvd  <= {r_dvd[14:0], 1'b0};
                r_cnt  <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

>>> rtl/core/pcs_mul.sv
`default_nettype none

module pcs_mul (
    input  wire logic             i_clk,
    input  wire pcs_pkg::t_level  i_ch,
    input  wire pcs_pkg::t_offset i_offset,
    input  wire pcs_pkg::t_gain   i_gain,
    output pcs_pkg::t_level       o_level
);
    import pcs_pkg::*;

    logic signed [9:0]  w_diff;
    logic signed [26:0] w_prod;
    logic signed [26:0] r_prod;

    always_comb begin
        w_diff = $signed({2'b00, i_ch}) - $signed({i_offset[8], i_offset});
        w_prod = 27'(w_diff) * 27'(i_gain);
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
    end

    // truncate q8.8, clamp to 0..255
    always_comb begin
        if (r_prod[26] || (r_prod == '0)) begin
            o_level = '0;
        end else if (|r_prod[25:16]) begin
            o_level = LEVEL_MAX;
        end else begin
            o_level = r_prod[15:8];
        end
    end

endmodule

`default_nettype wire

>>> sim/pixel_contrast_stretch_tb.sv
`default_nettype none

module pixel_contrast_stretch_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pcs_pkg::*;

    localparam int   DRAIN_CYCLES = 40;
    localparam int   CYCLE_LIMIT  = 400000;
    localparam int   RANDOM_ITEMS = 1650;

    typedef struct packed {
        t_level a;
        t_level b;
        t_level c;
    } t_pixel;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [23:0] s_data    = '0;
    logic [1:0]  s_user    = '0;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [23:0] m_data;
    logic        cfg_we    = 1'b0;
    t_cfg_idx    cfg_addr  = CFG_AUTO;
    logic [16:0] cfg_wdata = '0;

    // shadow of the block's registers and measurement state
    logic        reg_auto;
    t_color_mode reg_color;
    t_offset     reg_offset;
    t_gain       reg_gain;
    t_level      dark_lvl;
    t_level      bright_lvl;
    logic        gain_stale_m;
    logic [15:0] stretch_gain;

    t_pixel pending_pixels[$];

    int mismatches  = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int rx_holdoff  = 0;
    int rx_style    = 0;
    int rx_tick     = 0;
    bit tx_gappy    = 1'b0;

    pixel_contrast_stretch dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),    // ch_a, ch_b, ch_c
        .i_s_axis_tuser  (s_user),    // operation, first_of_frame
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),    // out_a, out_b, out_c
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what);
        $display("%0t error: %s", $time, what);
        mismatches++;
    endtask

    function automatic t_level scale_level(t_level ch, longint offs, longint gain);
        longint prod;
        prod = (longint'(ch) - offs) * gain;
        if (prod <= 0) begin
            return '0;
        end
        if ((prod >>> 8) > 255) begin
            return LEVEL_MAX;
        end
        return t_level'(prod >>> 8);
    endfunction

    function automatic void track_level(t_level v);
        if (v < dark_lvl) begin
            dark_lvl = v;
        end
        if (v > bright_lvl) begin
            bright_lvl = v;
        end
    endfunction

    function automatic void reset_shadow();
        reg_auto     = 1'b1;
        reg_color    = CM_RGB;
        reg_offset   = '0;
        reg_gain     = 17'sd256;
        dark_lvl     = LEVEL_MAX;
        bright_lvl   = '0;
        gain_stale_m = 1'b1;
        stretch_gain = '0;
    endfunction

    function automatic void predict_pixel(logic op, logic first, t_level a, t_level b,
                                          t_level c);
        longint offs;
        longint gain;
        t_pixel px;
        if (op == OP_MEASURE) begin
            if (first) begin
                dark_lvl   = LEVEL_MAX;
                bright_lvl = '0;
            end
            track_level(a);
            if (reg_color == CM_RGB || reg_color == CM_OTHER) begin
                track_level(b);
                track_level(c);
            end
            gain_stale_m = 1'b1;
            return;
        end
        if (gain_stale_m) begin
            if (bright_lvl > dark_lvl) begin
                stretch_gain = 16'(32'd65280 / (32'(bright_lvl) - 32'(dark_lvl)));
            end else begin
                stretch_gain = 16'hFFFF;
            end
            gain_stale_m = 1'b0;
        end
        if (reg_auto) begin
            offs = longint'(dark_lvl);
            gain = longint'(stretch_gain);
        end else begin
            offs = longint'(reg_offset);
            gain = longint'(reg_gain);
        end
        px.a = scale_level(a, offs, gain);
        case (reg_color)
            CM_GRAY: begin
                px.b = px.a;
                px.c = px.a;
            end
            CM_RGB: begin
                px.b = scale_level(b, offs, gain);
                px.c = scale_level(c, offs, gain);
            end
            default: begin
                px.b = b;
                px.c = c;
            end
        endcase
        pending_pixels.insert(pending_pixels.size(), px);
    endfunction

    task automatic send_item(logic op, logic first, t_level a, t_level b, t_level c);
        int gap;
        if (burst_left == 0) begin
            gap = 0;
            if (tx_gappy && $urandom_range(0, 2) != 0) begin
                gap = $urandom_range(1, 9);
            end
            if (gap > 0) begin
                @(negedge i_clk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        @(negedge i_clk);
        s_valid <= 1'b1;
        s_data  <= {c, b, a};
        s_user  <= {first, op};
        @(posedge i_clk);
        while (s_ready !== 1'b1) @(posedge i_clk);
        predict_pixel(op, first, a, b, c);
        burst_left--;
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic quiesce();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [16:0] value);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_AUTO:   reg_auto   = value[0];
            CFG_COLOR:  reg_color  = t_color_mode'(value[1:0]);
            CFG_OFFSET: reg_offset = value[8:0];
            CFG_GAIN:   reg_gain   = value;
            default:    ;
        endcase
    endtask

    task automatic test_reset_defaults();
        send_item(OP_APPLY, 1'b0, 8'd255, 8'd0, 8'd128);
        send_item(OP_APPLY, 1'b1, 8'd0, 8'd255, 8'd1);
    endtask

    task automatic test_auto_stretch();
        send_item(OP_MEASURE, 1'b1, 8'd40, 8'd100, 8'd60);
        send_item(OP_MEASURE, 1'b0, 8'd80, 8'd140, 8'd120);
        send_item(OP_APPLY, 1'b0, 8'd40, 8'd140, 8'd90);
        send_item(OP_APPLY, 1'b0, 8'd0, 8'd255, 8'd100);
        // measuring without a frame start widens the old range
        send_item(OP_MEASURE, 1'b0, 8'd20, 8'd20, 8'd20);
        send_item(OP_APPLY, 1'b0, 8'd30, 8'd200, 8'd255);
    endtask

    task automatic test_flat_frame();
        send_item(OP_MEASURE, 1'b1, 8'd77, 8'd77, 8'd77);
        send_item(OP_MEASURE, 1'b0, 8'd77, 8'd77, 8'd77);
        send_item(OP_APPLY, 1'b0, 8'd76, 8'd77, 8'd78);
    endtask

    task automatic test_color_modes();
        t_color_mode alt_modes [3];
        alt_modes = '{CM_GRAY, CM_YCC, CM_OTHER};
        foreach (alt_modes[i]) begin
            quiesce();
            cfg_write(CFG_COLOR, 17'(alt_modes[i]));
            send_item(OP_MEASURE, 1'b1, 8'd20, 8'd0, 8'd250);
            send_item(OP_MEASURE, 1'b0, 8'd220, 8'd5, 8'd3);
            send_item(OP_APPLY, 1'b0, 8'd120, 8'd33, 8'd66);
        end
    endtask

    task automatic test_manual_gain();
        quiesce();
        cfg_write(CFG_AUTO, 17'd0);
        cfg_write(CFG_COLOR, 17'(CM_RGB));
        cfg_write(CFG_OFFSET, 17'(-255));
        cfg_write(CFG_GAIN, 17'd65535);
        send_item(OP_APPLY, 1'b0, 8'd0, 8'd128, 8'd255);
        quiesce();
        cfg_write(CFG_OFFSET, 17'd255);
        cfg_write(CFG_GAIN, 17'd256);
        send_item(OP_APPLY, 1'b0, 8'd255, 8'd254, 8'd0);
        quiesce();
        cfg_write(CFG_OFFSET, 17'd0);
        cfg_write(CFG_GAIN, 17'h10000);
        send_item(OP_APPLY, 1'b0, 8'd10, 8'd0, 8'd255);
        quiesce();
        cfg_write(CFG_OFFSET, 17'd16);
        cfg_write(CFG_GAIN, 17'd383);
        send_item(OP_APPLY, 1'b0, 8'd100, 8'd16, 8'd15);
        quiesce();
        cfg_write(CFG_AUTO, 17'd1);
    endtask

    task automatic test_output_holdoff();
        quiesce();
        rx_holdoff = 300;
        tx_gappy   = 1'b0;
        burst_left = 0;
        for (int i = 0; i < 6; i++) begin
            send_item(OP_MEASURE, i == 0, 8'($urandom_range(30, 200)),
                      8'($urandom_range(30, 200)), 8'($urandom_range(30, 200)));
        end
        for (int i = 0; i < 34; i++) begin
            send_item(OP_APPLY, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_drain_pause();
        tx_gappy = 1'b1;
        rx_style = 2;
        for (int i = 0; i < 10; i++) begin
            send_item(i < 4 ? OP_MEASURE : OP_APPLY, i == 0, 8'($urandom),
                      8'($urandom), 8'($urandom));
        end
        wait_drained();
        for (int i = 0; i < 10; i++) begin
            send_item(OP_APPLY, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    task automatic test_random_frames();
        int start;
        int n_meas;
        int n_apply;
        int lo;
        int hi;
        int off_v;
        logic [16:0] gain_v;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                quiesce();
                cfg_write(CFG_AUTO, 17'($urandom_range(0, 3) != 0));
                cfg_write(CFG_COLOR, 17'($urandom_range(0, 3)));
                case ($urandom_range(0, 3))
                    0:       off_v = -255;
                    1:       off_v = 255;
                    default: off_v = int'($urandom_range(0, 510)) - 255;
                endcase
                cfg_write(CFG_OFFSET, 17'(off_v));
                case ($urandom_range(0, 4))
                    0:       gain_v = 17'h10000;
                    1:       gain_v = 17'd65535;
                    2:       gain_v = 17'($urandom_range(0, 1024));
                    default: gain_v = 17'($urandom);
                endcase
                cfg_write(CFG_GAIN, gain_v);
                rx_style = $urandom_range(0, 3);
                tx_gappy = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 9) < 8) begin
                lo = $urandom_range(0, 255);
                hi = $urandom_range(lo, 255);
                if ($urandom_range(0, 4) == 0) begin
                    lo = 0;
                    hi = 255;
                end
                n_meas  = $urandom_range(1, 10);
                n_apply = $urandom_range(1, 12);
                for (int i = 0; i < n_meas; i++) begin
                    send_item(OP_MEASURE, i == 0, 8'($urandom_range(lo, hi)),
                              8'($urandom_range(lo, hi)), 8'($urandom_range(lo, hi)));
                end
                for (int i = 0; i < n_apply; i++) begin
                    send_item(OP_APPLY, $urandom_range(0, 7) == 0,
                              8'($urandom), 8'($urandom), 8'($urandom));
                end
            end else begin
                // loose items: stray frame starts, applies with no fresh measure
                n_meas = $urandom_range(1, 10);
                for (int i = 0; i < n_meas; i++) begin
                    send_item(1'($urandom), 1'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_holdoff > 0) begin
            rx_holdoff--;
            m_ready <= 1'b0;
        end else begin
            case (rx_style)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                2:       m_ready <= ((rx_tick % 7) < 3);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : check_results
        t_pixel want;
        if (i_rst_n && m_valid === 1'b1 && m_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("result %h with no item pending", m_data));
            end else begin
                want = pending_pixels.pop_front();
                if (m_data[7:0] !== want.a) begin
                    report_mismatch($sformatf("out_a got %0d want %0d", m_data[7:0], want.a));
                end
                if (m_data[15:8] !== want.b) begin
                    report_mismatch($sformatf("out_b got %0d want %0d", m_data[15:8], want.b));
                end
                if (m_data[23:16] !== want.c) begin
                    report_mismatch($sformatf("out_c got %0d want %0d", m_data[23:16],
                                              want.c));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t error: timed out", $time);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        reset_shadow();
        rx_style = 1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_auto_stretch();
        test_flat_frame();
        test_color_modes();
        test_manual_gain();
        test_output_holdoff();
        test_drain_pause();
        test_random_frames();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> pixel_contrast_stretch.f
rtl/core/pcs_pkg.sv
rtl/core/pcs_div.sv
rtl/core/pcs_mul.sv
rtl/core/pixel_contrast_stretch.sv
sim/pixel_contrast_stretch_tb.sv
